// ----- hw/rtl/lzwd_pkg.sv -----
// shared types and constants of the lzss window decoder
`timescale 1ns / 1ps
package lzwd_pkg;

    localparam int WINDOW_BYTES = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_BYTES);
    localparam int CAP_W        = 25;
    localparam logic [CAP_W-1:0] CAP_RESET = 25'd16777216;

    // stream status codes
    localparam logic [1:0] STAT_RUN   = 2'd0;
    localparam logic [1:0] STAT_OK    = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_EARLY = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic copy_rd;
        logic copy_wr;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic start_copy;
        logic copy_done;
        logic out_free;
    } t_stat;

endpackage

// ----- hw/rtl/lzwd_ram.sv -----
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/lzwd_ctrl.sv -----
// sequencer for input acceptance and back-reference copies
`timescale 1ns / 1ps
module lzwd_ctrl
    import lzwd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_WR   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_ready;

    assign w_ready = (r_state == ST_IDLE) && i_stat.out_free;

    always_comb begin
        n_state       = r_state;
        o_cmd.accept  = 1'b0;
        o_cmd.copy_rd = 1'b0;
        o_cmd.copy_wr = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_ready && i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.start_copy) begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD: begin
                o_cmd.copy_rd = 1'b1;
                n_state       = ST_WR;
            end
            ST_WR: begin
                if (i_stat.out_free) begin
                    o_cmd.copy_wr = 1'b1;
                    n_state       = i_stat.copy_done ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = w_ready;

endmodule

// ----- hw/rtl/lzwd_datapath.sv -----
// token decode, counters, history window and output register
`timescale 1ns / 1ps
module lzwd_datapath
    import lzwd_pkg::*;
#(
    parameter int COUNT_BITS = 25
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CAP_W-1:0] i_cfg_wr_data,
    input  logic [7:0]       i_in_byte,
    input  logic             i_first,
    input  logic             i_last,
    input  logic             i_out_ready,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    output logic             o_out_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_out_bv,
    output logic             o_out_last,
    output logic [1:0]       o_out_status
);

    localparam int CMP_W = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 1;
    localparam logic [CMP_W-1:0] CMAX = CMP_W'((64'd1 << COUNT_BITS) - 64'd1);

    localparam logic [1:0] PH_FLAG   = 2'd0;
    localparam logic [1:0] PH_TOKEN  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    logic [CAP_W-1:0]      r_cap;
    logic [1:0]            r_phase,  n_phase;
    logic [7:0]            r_flag,   n_flag;
    logic [2:0]            r_tl,     n_tl;
    logic [7:0]            r_dh,     n_dh;
    logic [COUNT_BITS-1:0] r_bw,     n_bw;
    logic                  r_fin,    n_fin;
    logic [WIN_AW:0]       r_dist,   n_dist;
    logic [3:0]            r_left,   n_left;
    logic                  r_last_in, n_last_in;
    logic                  r_rd_zero, n_rd_zero;

    logic                  r_out_valid;
    logic [7:0]            r_out_byte;
    logic                  r_out_bv;
    logic                  r_out_last;
    logic [1:0]            r_out_status;

    logic [CMP_W-1:0]      w_limit;
    logic                  w_out_free;

    // load of the output register
    logic                  ld;
    logic [7:0]            ld_byte;
    logic                  ld_bv;
    logic                  ld_last;
    logic [1:0]            ld_status;

    logic                  ram_wr_en;
    logic [WIN_AW-1:0]     ram_wr_addr;
    logic [7:0]            ram_wr_data;
    logic                  ram_rd_en;
    logic [WIN_AW-1:0]     ram_rd_addr;
    logic [7:0]            ram_rd_data;
    logic                  start_copy;

    assign w_limit    = (CMP_W'(r_cap) < CMAX) ? CMP_W'(r_cap) : CMAX;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        logic [1:0]            e_phase;
        logic [7:0]            e_flag;
        logic [2:0]            e_tl;
        logic [COUNT_BITS-1:0] e_bw;
        logic                  e_fin;
        logic [1:0]            st;
        logic [WIN_AW:0]       ref_dist;
        logic [4:0]            len;

        e_phase  = i_first ? PH_FLAG : r_phase;
        e_flag   = i_first ? 8'd0 : r_flag;
        e_tl     = i_first ? 3'd0 : r_tl;
        e_bw     = i_first ? '0 : r_bw;
        e_fin    = i_first ? 1'b0 : r_fin;
        st       = STAT_RUN;
        ref_dist = {1'b0, r_dh, i_in_byte[7:4]} + (WIN_AW+1)'(1);
        len      = {1'b0, i_in_byte[3:0]} + 5'd1;

        n_phase   = r_phase;
        n_flag    = r_flag;
        n_tl      = r_tl;
        n_dh      = r_dh;
        n_bw      = r_bw;
        n_fin     = r_fin;
        n_dist    = r_dist;
        n_left    = r_left;
        n_last_in = r_last_in;
        n_rd_zero = r_rd_zero;

        ld        = 1'b0;
        ld_byte   = 8'd0;
        ld_bv     = 1'b0;
        ld_last   = 1'b1;
        ld_status = STAT_RUN;

        ram_wr_en   = 1'b0;
        ram_wr_addr = r_bw[WIN_AW-1:0];
        ram_wr_data = i_in_byte;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_bw[WIN_AW-1:0] - r_dist[WIN_AW-1:0];
        start_copy  = 1'b0;

        if (i_cmd.accept) begin
            n_phase = e_phase;
            n_flag  = e_flag;
            n_tl    = e_tl;
            n_bw    = e_bw;
            n_fin   = e_fin;
            if (i_first) begin
                n_dh = 8'd0;
            end
            if (!e_fin) begin
                if (e_phase != PH_SECOND && CMP_W'(e_bw) >= w_limit) begin
                    // limit lowered to or under the count: byte is dropped
                    st = STAT_FULL;
                end else begin
                    case (e_phase)
                        PH_TOKEN: begin
                            if (e_flag[0]) begin
                                n_dh    = i_in_byte;
                                n_phase = PH_SECOND;
                                st      = i_last ? STAT_EARLY : STAT_RUN;
                            end else begin
                                // literal
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = e_bw[WIN_AW-1:0];
                                n_bw        = e_bw + COUNT_BITS'(1);
                                n_flag      = {1'b0, e_flag[7:1]};
                                if (e_tl == 3'd0) begin
                                    n_phase = PH_FLAG;
                                end else begin
                                    n_tl    = e_tl - 3'd1;
                                    n_phase = PH_TOKEN;
                                end
                                ld_byte = i_in_byte;
                                ld_bv   = 1'b1;
                                if (CMP_W'(e_bw) + CMP_W'(1) >= w_limit) begin
                                    st = STAT_FULL;
                                end else begin
                                    st = i_last ? STAT_EARLY : STAT_RUN;
                                end
                                ld = 1'b1;
                            end
                        end
                        PH_SECOND: begin
                            if (i_in_byte[3:0] == 4'd0) begin
                                st = STAT_OK;
                            end else if (CMP_W'(e_bw) + CMP_W'(len) > w_limit) begin
                                st = STAT_FULL;
                            end else begin
                                // remaining count is length minus one
                                start_copy = 1'b1;
                                n_dist     = ref_dist;
                                n_left     = i_in_byte[3:0];
                                n_last_in  = i_last;
                            end
                        end
                        default: begin
                            // flag byte, unused phase code too
                            n_flag  = i_in_byte;
                            n_tl    = 3'd7;
                            n_phase = PH_TOKEN;
                            st      = i_last ? STAT_EARLY : STAT_RUN;
                        end
                    endcase
                end
                if (st != STAT_RUN) begin
                    n_fin = 1'b1;
                    ld    = 1'b1;
                end
                ld_status = st;
            end
        end

        if (i_cmd.copy_rd) begin
            ram_rd_en = 1'b1;
            n_rd_zero = r_bw < COUNT_BITS'(r_dist);
        end

        if (i_cmd.copy_wr) begin
            ld          = 1'b1;
            ld_bv       = 1'b1;
            ld_byte     = r_rd_zero ? 8'd0 : ram_rd_data;
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_bw[WIN_AW-1:0];
            ram_wr_data = ld_byte;
            n_bw        = r_bw + COUNT_BITS'(1);
            if (r_left == 4'd0) begin
                ld_last = 1'b1;
                n_flag  = {1'b0, r_flag[7:1]};
                if (r_tl == 3'd0) begin
                    n_phase = PH_FLAG;
                end else begin
                    n_tl    = r_tl - 3'd1;
                    n_phase = PH_TOKEN;
                end
                if (CMP_W'(r_bw) + CMP_W'(1) >= w_limit) begin
                    ld_status = STAT_FULL;
                end else begin
                    ld_status = r_last_in ? STAT_EARLY : STAT_RUN;
                end
                if (ld_status != STAT_RUN) begin
                    n_fin = 1'b1;
                end
            end else begin
                ld_last = 1'b0;
                n_left  = r_left - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_phase     <= PH_FLAG;
            r_flag      <= 8'd0;
            r_tl        <= 3'd0;
            r_dh        <= 8'd0;
            r_bw        <= '0;
            r_fin       <= 1'b0;
            r_left      <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            r_phase <= n_phase;
            r_flag  <= n_flag;
            r_tl    <= n_tl;
            r_dh    <= n_dh;
            r_bw    <= n_bw;
            r_fin   <= n_fin;
            r_left  <= n_left;
            if (ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist    <= n_dist;
        r_last_in <= n_last_in;
        r_rd_zero <= n_rd_zero;
        if (ld) begin
            r_out_byte   <= ld_byte;
            r_out_bv     <= ld_bv;
            r_out_last   <= ld_last;
            r_out_status <= ld_status;
        end
    end

    lzwd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_BYTES)
    ) u_window (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_stat.start_copy = start_copy;
    assign o_stat.copy_done  = (r_left == 4'd0);
    assign o_stat.out_free   = w_out_free;

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_out_bv     = r_out_bv;
    assign o_out_last   = r_out_last;
    assign o_out_status = r_out_status;

endmodule

// ----- hw/rtl/lzss_window_decoder.sv -----
// lzss decoder with a 4096-byte history window, top level
// a literal or status-only result is registered and shows in the cycle after its input transaction
// flag, literal and first reference bytes do not hold the input; the next byte is taken while the output drains
// a second reference byte that starts a copy holds the input until the copy ends (window read, then write)
// reset: synchronous active low, clears the decoder state and sets the capacity to 16777216
// the window ram is not cleared; reads before the first written byte give zero
`timescale 1ns / 1ps
module lzss_window_decoder
    import lzwd_pkg::*;
#(
    parameter int COUNT_BITS = 25
) (
    input  logic             i_clk,
    input  logic             i_rst_n,

    // capacity register write
    input  logic             i_cfg_wr_en,
    input  logic [CAP_W-1:0] i_cfg_wr_data,

    // compressed byte stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] in_byte
    input  logic [0:0]       s_axis_tuser,   // [0] first_of_stream
    input  logic             s_axis_tlast,   // last_of_stream

    // decoded byte stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]       m_axis_tuser,   // [0] byte_valid, [2:1] stream_status
    output logic             m_axis_tlast    // last_of_run
);

    t_cmd       cmd;
    t_stat      stat;
    logic       out_bv;
    logic [1:0] out_status;

    // controller: accepts a transaction and sequences the reference copy
    lzwd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: token decode, counters, window ram, output register
    lzwd_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_byte     (s_axis_tdata),
        .i_first       (s_axis_tuser[0]),
        .i_last        (s_axis_tlast),
        .i_out_ready   (m_axis_tready),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (m_axis_tvalid),
        .o_out_byte    (m_axis_tdata),
        .o_out_bv      (out_bv),
        .o_out_last    (m_axis_tlast),
        .o_out_status  (out_status)
    );

    // pack byte_valid low, status above it
    assign m_axis_tuser = {out_status, out_bv};

endmodule

// ----- hw/rtl/lzwd_checker.sv -----
// port-level assertions for the lzss window decoder and their bind
`timescale 1ns / 1ps
module lzwd_checker
    import lzwd_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cfg_wr_en,
    input logic [CAP_W-1:0] i_cfg_wr_data,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [7:0]       s_axis_tdata,
    input logic [0:0]       s_axis_tuser,
    input logic             s_axis_tlast,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [7:0]       m_axis_tdata,
    input logic [2:0]       m_axis_tuser,
    input logic             m_axis_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
        && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // a result with no byte only carries a final status
    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
        m_axis_tlast && (m_axis_tuser[2:1] != STAT_RUN) && (m_axis_tdata == 8'd0))
        else $error("malformed status-only result");

    // a final status closes the run
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[2:1] != STAT_RUN) |-> m_axis_tlast)
        else $error("status on a result that is not last");

    // input is taken only when the output stage can take its result
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tready)
        else $error("input ready while output is stalled");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind lzss_window_decoder lzwd_checker u_lzwd_checker (.*);
